FILE: hw/rtl/urm_pkg.sv
`timescale 1ns / 1ps

package urm_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_STATUS   = 3'd1,
    REG_TRANSMIT = 3'd2,
    REG_RECEIVE  = 3'd3,
    REG_RATE     = 3'd4,
    REG_NONE5    = 3'd5,
    REG_NONE6    = 3'd6,
    REG_NONE7    = 3'd7
  } reg_e;

  localparam logic [15:0] ModeTxie   = 16'h0800;
  localparam logic [15:0] ModeRxie   = 16'h0400;
  localparam logic [15:0] StatTemt   = 16'h0040;
  localparam logic [15:0] StatThre   = 16'h0020;
  localparam logic [15:0] StatRdr    = 16'h0010;
  localparam logic [15:0] PollReset  = 16'd5000;
  localparam logic [15:0] ModeReset  = ModeRxie;
  localparam logic [15:0] StatReset  = StatTemt | StatThre;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 32;

  typedef struct packed {
    logic [3:0]  port_offset;
    logic [15:0] write_data;
    logic        rx_available;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_taken;
    logic        overrun;
    logic        irq;
  } result_t;

endpackage

FILE: hw/rtl/uart_register_model.sv
`timescale 1ns / 1ps
// The result of an accepted word is registered and shows on the next cycle.
// Throughput: one word per cycle; the output register frees in the cycle it is taken,
// so the input stalls only while a result waits and the master side holds tready low.
// Reset (rst_ni low, asynchronous): registers take their power-on values, the poll
// interval returns to 5000 and the output register empties.
module uart_register_model (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] port_offset, [19:4] write_data, [20] rx_available, [28:21] rx_byte, rest zero
  input  logic [31:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] read_data, [16] tx_valid, [24:17] tx_byte, [25] rx_taken, [26] overrun,
  // [27] irq, rest zero
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import urm_pkg::*;

  logic    accept;
  item_t   item;
  result_t result;
  result_t out_q;
  logic    out_valid_q, out_valid_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign item.port_offset  = s_axis_tdata[3:0];
  assign item.write_data   = s_axis_tdata[19:4];
  assign item.rx_available = s_axis_tdata[20];
  assign item.rx_byte      = s_axis_tdata[28:21];

  urm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (cmd_e'(s_axis_tuser)),
    .item_i     (item),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (result)
  );

  assign out_valid_d = accept || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.irq, out_q.overrun, out_q.rx_taken, out_q.tx_byte,
                          out_q.tx_valid, out_q.read_data};

endmodule

FILE: hw/rtl/urm_core.sv
`timescale 1ns / 1ps

module urm_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  urm_pkg::cmd_e   cmd_i,
  input  urm_pkg::item_t  item_i,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_data_i,
  output urm_pkg::result_t result_o
);
  import urm_pkg::*;

  logic [15:0] poll_q, poll_d;
  logic [15:0] mode_q, mode_d;
  logic [15:0] status_q, status_d;
  logic [15:0] transmit_q, transmit_d;
  logic [15:0] receive_q, receive_d;
  logic [15:0] rate_q, rate_d;
  logic [15:0] tick_q, tick_d;

  reg_e        reg_sel;
  logic [16:0] tick_next;
  logic [15:0] stat_rx;

  assign reg_sel   = reg_e'(item_i.port_offset[3:1]);
  assign tick_next = {1'b0, tick_q} + 17'd1;

  always_comb begin
    poll_d     = cfg_we_i ? cfg_data_i : poll_q;
    mode_d     = mode_q;
    status_d   = status_q;
    transmit_d = transmit_q;
    receive_d  = receive_q;
    rate_d     = rate_q;
    tick_d     = tick_q;
    stat_rx    = status_q;
    result_o   = '0;

    case (cmd_i)
      CMD_READ: begin
        case (reg_sel)
          REG_MODE:     result_o.read_data = mode_q;
          REG_STATUS:   result_o.read_data = status_q;
          REG_TRANSMIT: result_o.read_data = transmit_q;
          REG_RECEIVE: begin
            result_o.read_data = receive_q;
            status_d = status_q & ~StatRdr;
          end
          REG_RATE:     result_o.read_data = rate_q;
          default:      result_o.read_data = '0;
        endcase
      end
      CMD_WRITE: begin
        case (reg_sel)
          REG_MODE:   mode_d = item_i.write_data;
          REG_STATUS: status_d = item_i.write_data;
          REG_TRANSMIT: begin
            transmit_d = item_i.write_data;
            status_d   = status_q & ~(StatTemt | StatThre);
          end
          REG_RECEIVE: receive_d = item_i.write_data;
          REG_RATE:    rate_d = item_i.write_data;
          default: ;
        endcase
      end
      CMD_TICK: begin
        // The receive poll comes first; the send then sees its status.
        if (tick_next < {1'b0, poll_q}) begin
          tick_d = tick_next[15:0];
        end else begin
          tick_d = '0;
          if (item_i.rx_available) begin
            result_o.overrun  = (status_q & StatRdr) != '0;
            result_o.rx_taken = 1'b1;
            receive_d = {8'd0, item_i.rx_byte};
            stat_rx   = status_q | StatRdr;
          end
        end
        status_d = stat_rx;
        if ((stat_rx & StatThre) == '0) begin
          result_o.tx_valid = 1'b1;
          result_o.tx_byte  = transmit_q[7:0];
          status_d = stat_rx | StatTemt | StatThre;
        end
      end
      default: ;
    endcase

    result_o.irq = (((status_d & StatRdr) != '0) && ((mode_d & ModeRxie) != '0)) ||
                   (((status_d & StatThre) != '0) && ((mode_d & ModeTxie) != '0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_q     <= PollReset;
      mode_q     <= ModeReset;
      status_q   <= StatReset;
      transmit_q <= '0;
      receive_q  <= '0;
      rate_q     <= '0;
      tick_q     <= '0;
    end else begin
      poll_q <= poll_d;
      if (accept_i) begin
        mode_q     <= mode_d;
        status_q   <= status_d;
        transmit_q <= transmit_d;
        receive_q  <= receive_d;
        rate_q     <= rate_d;
        tick_q     <= tick_d;
      end
    end
  end

endmodule

FILE: hw/rtl/urm_checker.sv
`timescale 1ns / 1ps

module urm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  import urm_pkg::*;

  // A waiting result holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // Every accepted word yields a result in the next cycle.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // The input never stalls while the output register is empty.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Only a bus read returns register data.
  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_READ)
      |=> m_axis_tdata[15:0] == 16'd0)
    else $error("read data on a non-read word");

endmodule

bind uart_register_model urm_checker u_urm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
